FILE: rtl/laf_pkg.sv
// Shared types and register codes for the Lambertian alignment factor block.
package laf_pkg;

  // Configuration register codes, by word address.
  typedef enum logic [1:0] {
    REG_LIGHT_X = 2'd0,
    REG_LIGHT_Y = 2'd1,
    REG_LIGHT_Z = 2'd2
  } laf_reg_t;

  // Sideband that travels with each request through the deep stages.
  typedef struct packed {
    logic degenerate;
    logic dot_neg;
  } laf_tag_t;

endpackage

FILE: rtl/laf_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module laf_div #(
  parameter int DW = 96,
  parameter int QW = 126,
  parameter int QB = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  laf_pkg::laf_tag_t    in_tag,
  input  logic [DW-1:0]        divisor,
  input  logic [QW-1:0]        dividend,
  output logic                 out_valid,
  output laf_pkg::laf_tag_t    out_tag,
  output logic [QB-1:0]        quotient
);
  import laf_pkg::*;

  logic [QW-1:0] rem   [QB+1];
  logic [QB-1:0] quo   [QB+1];
  logic [DW-1:0] dvs   [QB+1];
  logic          valid [QB+1];
  laf_tag_t      tag   [QB+1];

  assign rem[0]   = dividend;
  assign quo[0]   = '0;
  assign dvs[0]   = divisor;
  assign valid[0] = in_valid;
  assign tag[0]   = in_tag;

  // Each stage tries the divisor shifted to the next quotient bit.
  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int B = QB - 1 - j;
    logic [QW-1:0] shifted;
    logic          fits;

    assign shifted = QW'(dvs[j]) << B;
    assign fits    = rem[j] >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j+1] <= 1'b0;
      end else if (adv) begin
        valid[j+1] <= valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j+1] <= fits ? rem[j] - shifted : rem[j];
        quo[j+1] <= quo[j] | (QB'(fits) << B);
        dvs[j+1] <= dvs[j];
        tag[j+1] <= tag[j];
      end
    end
  end

  assign out_valid = valid[QB];
  assign out_tag   = tag[QB];
  assign quotient  = quo[QB];

  // The ratio never exceeds the full-scale square for a proper vector pair.
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_tag.degenerate |-> quotient <= (QB'(1) << (QB - 1)))
    else $error("quotient above full scale");

  // A request at the divider output stays there while the pipeline does not advance.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !adv && out_valid |=> out_valid)
    else $error("divider dropped a held request");

  // The output tag stays unchanged through a held stage.
  a_tag_hold: assert property (@(posedge clk) disable iff (rst)
    !adv && out_valid |=> $stable(out_tag))
    else $error("divider tag changed while held");

endmodule

FILE: rtl/laf_sqrt.sv
// Pipelined integer square root: one root bit per register stage.
module laf_sqrt #(
  parameter int RW = 31,
  parameter int MW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  laf_pkg::laf_tag_t    in_tag,
  input  logic [RW-1:0]        radicand,
  output logic                 out_valid,
  output laf_pkg::laf_tag_t    out_tag,
  output logic [MW-1:0]        root
);
  import laf_pkg::*;

  logic [RW-1:0] rad   [MW+1];
  logic [MW-1:0] rt    [MW+1];
  logic          valid [MW+1];
  laf_tag_t      tag   [MW+1];

  assign rad[0]   = radicand;
  assign rt[0]    = '0;
  assign valid[0] = in_valid;
  assign tag[0]   = in_tag;

  // Each stage keeps the trial bit when its square does not exceed the radicand.
  for (genvar j = 0; j < MW; j++) begin : g_stage
    localparam int B = MW - 1 - j;
    logic [MW-1:0]   cand;
    logic [2*MW-1:0] sq;

    assign cand = rt[j] | (MW'(1) << B);
    assign sq   = (2*MW)'(cand) * (2*MW)'(cand);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j+1] <= 1'b0;
      end else if (adv) begin
        valid[j+1] <= valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad[j+1] <= rad[j];
        rt[j+1]  <= (sq <= (2*MW)'(rad[j])) ? cand : rt[j];
        tag[j+1] <= tag[j];
      end
    end
  end

  assign out_valid = valid[MW];
  assign out_tag   = tag[MW];
  assign root      = rt[MW];

endmodule

FILE: rtl/lambert_alignment_factor.sv
// Top level of the Lambertian alignment factor pipeline.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  normal    | normal_valid/normal_stall | normal_x, normal_y, normal_z
//  result    | result_valid/result_stall | alignment, degenerate
//  config    | APB psel/penable/pready   | light_dir_x/y/z at 0x0, 0x4, 0x8
//
// One request is taken every cycle unless a valid result stalls; the path runs
// through six front stages, the restoring divider (2*FACTOR_BITS-1 stages),
// the square root (FACTOR_BITS stages) and the output register.
// Reset is synchronous, clears valid bits and loads the light direction (0, 0, 1).
// A stall on a valid result holds every stage; normal_stall follows at once.
module lambert_alignment_factor #(
  parameter int COMPONENT_BITS = 24,
  parameter int FACTOR_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              normal_valid,
  output logic                              normal_stall,
  input  logic signed [COMPONENT_BITS-1:0]  normal_x,
  input  logic signed [COMPONENT_BITS-1:0]  normal_y,
  input  logic signed [COMPONENT_BITS-1:0]  normal_z,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [FACTOR_BITS-1:0]     alignment,
  output logic                              degenerate
);
  import laf_pkg::*;

  localparam int C  = COMPONENT_BITS;
  localparam int F  = FACTOR_BITS;
  localparam int PW = 4 * C;
  localparam int QW = 4 * C + 2 * (F - 1);
  localparam int QB = 2 * F - 1;

  logic adv;

  // Light direction registers.
  logic [C-1:0] light [3];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light[0] <= '0;
      light[1] <= '0;
      light[2] <= C'(1);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_LIGHT_X: light[0] <= pwdata[C-1:0];
        REG_LIGHT_Y: light[1] <= pwdata[C-1:0];
        REG_LIGHT_Z: light[2] <= pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LIGHT_X: prdata = 32'(signed'(light[0]));
      REG_LIGHT_Y: prdata = 32'(signed'(light[1]));
      REG_LIGHT_Z: prdata = 32'(signed'(light[2]));
      default:     prdata = '0;
    endcase
  end

  // The whole pipeline moves when the output register is free or taken.
  assign adv          = !result_valid || !result_stall;
  assign normal_stall = !adv;

  // Stage 1: sign and magnitude of each component.
  logic [C-1:0] nraw [3];
  logic [C-1:0] mn1 [3];
  logic [C-1:0] ml1 [3];
  logic         sx1 [3];
  logic         v1;

  assign nraw[0] = normal_x;
  assign nraw[1] = normal_y;
  assign nraw[2] = normal_z;

  for (genvar i = 0; i < 3; i++) begin : g_mag
    always_ff @(posedge clk) begin
      if (adv) begin
        mn1[i] <= nraw[i][C-1] ? C'(-nraw[i]) : nraw[i];
        ml1[i] <= light[i][C-1] ? C'(-light[i]) : light[i];
        sx1[i] <= nraw[i][C-1] ^ light[i][C-1];
      end
    end
  end

  // Stage 2: component products and squares.
  logic [2*C-1:0] p2 [3];
  logic [2*C-1:0] nq2 [3];
  logic [2*C-1:0] lq2 [3];
  logic           sx2 [3];
  logic           v2;

  for (genvar i = 0; i < 3; i++) begin : g_prod
    always_ff @(posedge clk) begin
      if (adv) begin
        p2[i]  <= (2*C)'(mn1[i]) * (2*C)'(ml1[i]);
        nq2[i] <= (2*C)'(mn1[i]) * (2*C)'(mn1[i]);
        lq2[i] <= (2*C)'(ml1[i]) * (2*C)'(ml1[i]);
      end
    end
  end

  // Stage 3: product sums split by sign of each term, and squared-length sums.
  logic [2*C-1:0] pos3, neg3, nn3, ll3;
  logic           v3;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx2  <= sx1;
      pos3 <= (sx2[0] ? '0 : p2[0]) + (sx2[1] ? '0 : p2[1]) + (sx2[2] ? '0 : p2[2]);
      neg3 <= (sx2[0] ? p2[0] : '0) + (sx2[1] ? p2[1] : '0) + (sx2[2] ? p2[2] : '0);
      nn3  <= nq2[0] + nq2[1] + nq2[2];
      ll3  <= lq2[0] + lq2[1] + lq2[2];
    end
  end

  // Stage 4: dot product magnitude and the zero-length check.
  logic [2*C-1:0] dm4, nn4, ll4;
  laf_tag_t       tag4;
  logic           v4;

  always_ff @(posedge clk) begin
    if (adv) begin
      dm4             <= (neg3 > pos3) ? neg3 - pos3 : pos3 - neg3;
      tag4.dot_neg    <= neg3 > pos3;
      tag4.degenerate <= (nn3 == '0) || (ll3 == '0);
      nn4             <= nn3;
      ll4             <= ll3;
    end
  end

  // Stage 5: half-width partial products of nn*ll and dot^2.
  logic [2*C-1:0] nl_hh, nl_hl, nl_lh, nl_ll;
  logic [2*C-1:0] dd_hh, dd_hl, dd_ll;
  laf_tag_t       tag5;
  logic           v5;

  always_ff @(posedge clk) begin
    if (adv) begin
      nl_hh <= (2*C)'(nn4[2*C-1:C]) * (2*C)'(ll4[2*C-1:C]);
      nl_hl <= (2*C)'(nn4[2*C-1:C]) * (2*C)'(ll4[C-1:0]);
      nl_lh <= (2*C)'(nn4[C-1:0])   * (2*C)'(ll4[2*C-1:C]);
      nl_ll <= (2*C)'(nn4[C-1:0])   * (2*C)'(ll4[C-1:0]);
      dd_hh <= (2*C)'(dm4[2*C-1:C]) * (2*C)'(dm4[2*C-1:C]);
      dd_hl <= (2*C)'(dm4[2*C-1:C]) * (2*C)'(dm4[C-1:0]);
      dd_ll <= (2*C)'(dm4[C-1:0])   * (2*C)'(dm4[C-1:0]);
      tag5  <= tag4;
    end
  end

  // Stage 6: full products; the dividend carries the fraction scaling.
  logic [PW-1:0] nl6;
  logic [QW-1:0] lhs6;
  laf_tag_t      tag6;
  logic          v6;

  always_ff @(posedge clk) begin
    if (adv) begin
      nl6  <= (PW'(nl_hh) << (2*C)) + ((PW'(nl_hl) + PW'(nl_lh)) << C) + PW'(nl_ll);
      lhs6 <= QW'((PW'(dd_hh) << (2*C)) + (PW'(dd_hl) << (C + 1)) + PW'(dd_ll))
              << (2 * (F - 1));
      tag6 <= tag5;
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= normal_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Ratio of the squared dot product to the squared lengths.
  logic          vd;
  laf_tag_t      tagd;
  logic [QB-1:0] ratio;

  laf_div #(.DW(PW), .QW(QW), .QB(QB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (v6),
    .in_tag   (tag6),
    .divisor  (nl6),
    .dividend (lhs6),
    .out_valid(vd),
    .out_tag  (tagd),
    .quotient (ratio)
  );

  // Square root gives the truncated cosine magnitude.
  logic         vs;
  laf_tag_t     tags;
  logic [F-1:0] mag;

  laf_sqrt #(.RW(QB), .MW(F)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (vd),
    .in_tag   (tagd),
    .radicand (ratio),
    .out_valid(vs),
    .out_tag  (tags),
    .root     (mag)
  );

  // Output register: clamp, apply the negated sign, force zero when degenerate.
  localparam logic [F-1:0] TOP = F'(1) << (F - 1);
  logic [F-1:0] mag_cl;

  assign mag_cl = (mag > TOP) ? TOP : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      degenerate <= tags.degenerate;
      if (tags.degenerate) begin
        alignment <= '0;
      end else if (tags.dot_neg) begin
        alignment <= (mag_cl > TOP - F'(1)) ? TOP - F'(1) : mag_cl;
      end else begin
        alignment <= F'(-mag_cl);
      end
    end
  end

  // A degenerate result always carries a zero factor.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |-> alignment == '0)
    else $error("degenerate result with nonzero factor");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result keeps the whole pipeline and the input held.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> normal_stall)
    else $error("input taken while result stalled");

endmodule
